// File: sv/sct_pkg.sv
// ----------------------------------------------------------------------------
// Segment crossing test package
// Word formats, stage formats and outcome codes shared by the pipeline.
// ----------------------------------------------------------------------------
package sct_pkg;

  // Field widths of an input word.
  localparam int CoordWidth = 12;
  localparam int IdWidth    = 10;

  // Arithmetic widths derived from the coordinate width.
  localparam int DiffWidth  = CoordWidth + 1;        // signed coordinate difference
  localparam int ProdWidth  = 2 * CoordWidth;        // unsigned coordinate product
  localparam int CrossWidth = 2 * CoordWidth + 1;    // signed line constant
  localparam int DetWidth   = 2 * CoordWidth + 3;    // signed determinant
  localparam int AbsWidth   = DetWidth - 1;          // magnitude of the determinant
  localparam int NumWidth   = 3 * CoordWidth + 3;    // signed intersection numerator
  localparam int BoundWidth = NumWidth - 1;          // bound times determinant magnitude

  // Outcome codes.
  typedef enum logic [1:0] {
    OUT_SHARED   = 2'd0,
    OUT_PARALLEL = 2'd1,
    OUT_OUTSIDE  = 2'd2,
    OUT_CROSS    = 2'd3
  } outcome_t;

  // Input word: two segments with vertex ids.
  typedef struct packed {
    logic [IdWidth-1:0]    a_start_id;
    logic [CoordWidth-1:0] a_start_x;
    logic [CoordWidth-1:0] a_start_y;
    logic [IdWidth-1:0]    a_end_id;
    logic [CoordWidth-1:0] a_end_x;
    logic [CoordWidth-1:0] a_end_y;
    logic [IdWidth-1:0]    b_start_id;
    logic [CoordWidth-1:0] b_start_x;
    logic [CoordWidth-1:0] b_start_y;
    logic [IdWidth-1:0]    b_end_id;
    logic [CoordWidth-1:0] b_end_x;
    logic [CoordWidth-1:0] b_end_y;
  } item_t;

  // Result word.
  typedef struct packed {
    logic       crosses;
    logic [1:0] outcome;
  } result_t;

  // Inclusive bounding box of one segment.
  typedef struct packed {
    logic [CoordWidth-1:0] lox;
    logic [CoordWidth-1:0] hix;
    logic [CoordWidth-1:0] loy;
    logic [CoordWidth-1:0] hiy;
  } box_t;

  // Second stage: determinant and line constants.
  typedef struct packed {
    logic                        shared;
    logic signed [DiffWidth-1:0] dxa;
    logic signed [DiffWidth-1:0] dya;
    logic signed [DiffWidth-1:0] dxb;
    logic signed [DiffWidth-1:0] dyb;
    logic signed [DetWidth-1:0]  det;
    logic signed [CrossWidth-1:0] ca;
    logic signed [CrossWidth-1:0] cb;
    box_t                        abox;
    box_t                        bbox;
  } s2_t;

  // Third stage: numerators and determinant magnitude and sign.
  typedef struct packed {
    logic                       shared;
    logic                       zero;
    logic                       neg;
    logic [AbsWidth-1:0]        absdet;
    logic signed [NumWidth-1:0] nx;
    logic signed [NumWidth-1:0] ny;
    box_t                       abox;
    box_t                       bbox;
  } s3_t;

endpackage

// File: sv/sct_front.sv
// ----------------------------------------------------------------------------
// Segment crossing test front end
// Stage one forms differences, coordinate products, id matches and boxes;
// stage two forms the determinant and both line constants.
// ----------------------------------------------------------------------------
module sct_front import sct_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  item_t item,
  output s2_t   s2
);

  typedef struct packed {
    logic                        shared;
    logic signed [DiffWidth-1:0] dxa;
    logic signed [DiffWidth-1:0] dya;
    logic signed [DiffWidth-1:0] dxb;
    logic signed [DiffWidth-1:0] dyb;
    logic [ProdWidth-1:0]        p1;
    logic [ProdWidth-1:0]        p2;
    logic [ProdWidth-1:0]        p3;
    logic [ProdWidth-1:0]        p4;
    box_t                        abox;
    box_t                        bbox;
  } s1_t;

  s1_t s1;
  s1_t s1_next;
  s2_t s2_next;

  // Stage one: any shared vertex id, differences, products and boxes.
  always_comb begin
    s1_next.shared = (item.a_start_id == item.b_start_id) ||
                     (item.a_start_id == item.b_end_id) ||
                     (item.a_end_id == item.b_start_id) ||
                     (item.a_end_id == item.b_end_id);
    s1_next.dxa = $signed({1'b0, item.a_start_x}) - $signed({1'b0, item.a_end_x});
    s1_next.dya = $signed({1'b0, item.a_start_y}) - $signed({1'b0, item.a_end_y});
    s1_next.dxb = $signed({1'b0, item.b_start_x}) - $signed({1'b0, item.b_end_x});
    s1_next.dyb = $signed({1'b0, item.b_start_y}) - $signed({1'b0, item.b_end_y});
    s1_next.p1  = item.a_start_x * item.a_end_y;
    s1_next.p2  = item.a_start_y * item.a_end_x;
    s1_next.p3  = item.b_start_x * item.b_end_y;
    s1_next.p4  = item.b_start_y * item.b_end_x;
    if (item.a_start_x < item.a_end_x) begin
      s1_next.abox.lox = item.a_start_x;
      s1_next.abox.hix = item.a_end_x;
    end else begin
      s1_next.abox.lox = item.a_end_x;
      s1_next.abox.hix = item.a_start_x;
    end
    if (item.a_start_y < item.a_end_y) begin
      s1_next.abox.loy = item.a_start_y;
      s1_next.abox.hiy = item.a_end_y;
    end else begin
      s1_next.abox.loy = item.a_end_y;
      s1_next.abox.hiy = item.a_start_y;
    end
    if (item.b_start_x < item.b_end_x) begin
      s1_next.bbox.lox = item.b_start_x;
      s1_next.bbox.hix = item.b_end_x;
    end else begin
      s1_next.bbox.lox = item.b_end_x;
      s1_next.bbox.hix = item.b_start_x;
    end
    if (item.b_start_y < item.b_end_y) begin
      s1_next.bbox.loy = item.b_start_y;
      s1_next.bbox.hiy = item.b_end_y;
    end else begin
      s1_next.bbox.loy = item.b_end_y;
      s1_next.bbox.hiy = item.b_start_y;
    end
  end

  // Stage two: determinant of the two directions and the line constants.
  always_comb begin
    s2_next.shared = s1.shared;
    s2_next.dxa    = s1.dxa;
    s2_next.dya    = s1.dya;
    s2_next.dxb    = s1.dxb;
    s2_next.dyb    = s1.dyb;
    s2_next.det    = s1.dxa * s1.dyb - s1.dya * s1.dxb;
    s2_next.ca     = $signed({1'b0, s1.p1}) - $signed({1'b0, s1.p2});
    s2_next.cb     = $signed({1'b0, s1.p3}) - $signed({1'b0, s1.p4});
    s2_next.abox   = s1.abox;
    s2_next.bbox   = s1.bbox;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
    end
  end

endmodule

// File: sv/sct_numer.sv
// ----------------------------------------------------------------------------
// Segment crossing test numerator stage
// Forms the intersection numerators and splits the determinant into
// magnitude, sign and a zero flag.
// ----------------------------------------------------------------------------
module sct_numer import sct_pkg::*; (
  input  logic clk,
  input  logic en,
  input  s2_t  s2,
  output s3_t  s3
);

  s3_t                       s3_next;
  logic signed [DetWidth-1:0] negdet;

  // Cross-multiplied numerators of the intersection point.
  always_comb begin
    negdet         = -s2.det;
    s3_next.shared = s2.shared;
    s3_next.zero   = (s2.det == '0);
    s3_next.neg    = s2.det[DetWidth-1];
    s3_next.absdet = s2.det[DetWidth-1] ? negdet[AbsWidth-1:0] : s2.det[AbsWidth-1:0];
    s3_next.nx     = s2.ca * s2.dxb - s2.dxa * s2.cb;
    s3_next.ny     = s2.ca * s2.dyb - s2.dya * s2.cb;
    s3_next.abox   = s2.abox;
    s3_next.bbox   = s2.bbox;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3 <= s3_next;
    end
  end

endmodule

// File: sv/sct_box.sv
// ----------------------------------------------------------------------------
// Segment crossing test box stage
// Scales every box bound by the determinant magnitude, then compares the
// sign-corrected numerators against them and picks the outcome.
// ----------------------------------------------------------------------------
module sct_box import sct_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  s3_t      s3,
  output outcome_t outcome
);

  typedef struct packed {
    logic                       shared;
    logic                       zero;
    logic signed [NumWidth-1:0] nx;
    logic signed [NumWidth-1:0] ny;
    logic [BoundWidth-1:0]      alox;
    logic [BoundWidth-1:0]      ahix;
    logic [BoundWidth-1:0]      aloy;
    logic [BoundWidth-1:0]      ahiy;
    logic [BoundWidth-1:0]      blox;
    logic [BoundWidth-1:0]      bhix;
    logic [BoundWidth-1:0]      bloy;
    logic [BoundWidth-1:0]      bhiy;
  } s4_t;

  s4_t  s4;
  s4_t  s4_next;
  logic in_a;
  logic in_b;

  // Flip the numerator signs for a negative determinant and scale the bounds by its magnitude.
  always_comb begin
    s4_next.shared = s3.shared;
    s4_next.zero   = s3.zero;
    s4_next.nx     = s3.neg ? -s3.nx : s3.nx;
    s4_next.ny     = s3.neg ? -s3.ny : s3.ny;
    s4_next.alox   = s3.abox.lox * s3.absdet;
    s4_next.ahix   = s3.abox.hix * s3.absdet;
    s4_next.aloy   = s3.abox.loy * s3.absdet;
    s4_next.ahiy   = s3.abox.hiy * s3.absdet;
    s4_next.blox   = s3.bbox.lox * s3.absdet;
    s4_next.bhix   = s3.bbox.hix * s3.absdet;
    s4_next.bloy   = s3.bbox.loy * s3.absdet;
    s4_next.bhiy   = s3.bbox.hiy * s3.absdet;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4 <= s4_next;
    end
  end

  // Inclusive containment in both boxes, then the outcome in priority order.
  always_comb begin
    in_a = (s4.nx >= $signed({1'b0, s4.alox})) && (s4.nx <= $signed({1'b0, s4.ahix})) &&
           (s4.ny >= $signed({1'b0, s4.aloy})) && (s4.ny <= $signed({1'b0, s4.ahiy}));
    in_b = (s4.nx >= $signed({1'b0, s4.blox})) && (s4.nx <= $signed({1'b0, s4.bhix})) &&
           (s4.ny >= $signed({1'b0, s4.bloy})) && (s4.ny <= $signed({1'b0, s4.bhiy}));
    if (s4.shared) begin
      outcome = OUT_SHARED;
    end else if (s4.zero) begin
      outcome = OUT_PARALLEL;
    end else if (in_a && in_b) begin
      outcome = OUT_CROSS;
    end else begin
      outcome = OUT_OUTSIDE;
    end
  end

endmodule

// File: sv/segment_crossing_test_unit.sv
// ----------------------------------------------------------------------------
// Segment crossing test unit
// Tests whether two integer line segments cross, one pair per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// The unit takes one word per clock while the output is not stalled and
// returns one result word per input word, in order. Each word passes
// through five register stages, the first of which captures the input word
// at the accepting edge: differences and coordinate products, determinant
// and line constants, intersection numerators, bounds scaled by the
// determinant, and the output register holding the final compare. A stall
// on the output freezes every stage at once, so the input is stalled exactly
// while a result waits to be taken.
// Segments sharing a vertex id report a shared vertex; a zero determinant
// reports parallel or collinear; otherwise the exact intersection point is
// tested against both bounding boxes with the bounds included.
module segment_crossing_test_unit import sct_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int Stages = 4;

  logic              en;
  logic [Stages-1:0] vld;
  s2_t               s2;
  s3_t               s3;
  outcome_t          outcome;

  // The whole pipeline advances unless a finished word is held at the output.
  assign en         = !result_valid || !result_stall;
  assign item_stall = !en;

  sct_front u_front (
    .clk  (clk),
    .en   (en),
    .item (item),
    .s2   (s2)
  );

  sct_numer u_numer (
    .clk (clk),
    .en  (en),
    .s2  (s2),
    .s3  (s3)
  );

  sct_box u_box (
    .clk     (clk),
    .en      (en),
    .s3      (s3),
    .outcome (outcome)
  );

  // Valid bits travel alongside the data stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
    end else if (en) begin
      vld          <= {vld[Stages-2:0], item_valid};
      result_valid <= vld[Stages-1];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      result.crosses <= (outcome == OUT_CROSS);
      result.outcome <= outcome;
    end
  end

  // The crossing flag agrees with the outcome code.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.crosses == (result.outcome == OUT_CROSS)))
    else $error("crossing flag disagrees with outcome");

  // A held result freezes the valid bits of every stage.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (vld == $past(vld)))
    else $error("pipeline moved while the output was stalled");

  // Reset empties the pipeline.
  assert property (@(posedge clk)
    rst |=> (!result_valid && (vld == '0)))
    else $error("pipeline not empty after reset");

endmodule
